// ===== hw/rtl/hcd_pkg.sv =====
// types, codes and constants shared by the hill cipher decrypt stream
package hcd_pkg;

    localparam int LETTER_W = 5;
    localparam int CHAR_W   = 7;
    localparam int KEY_W    = 15;
    localparam int SUM_W    = 12;
    localparam int CFG_IDX_W = 2;

    // operation codes of an input item
    localparam logic [1:0] OP_LETTER = 2'd0;
    localparam logic [1:0] OP_SPACE  = 2'd1;
    localparam logic [1:0] OP_EOL    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW2 = 2'd2;

    localparam logic [KEY_W-1:0] KEY_ROW0_RESET = 15'd10408;
    localparam logic [KEY_W-1:0] KEY_ROW1_RESET = 15'd21781;
    localparam logic [KEY_W-1:0] KEY_ROW2_RESET = 15'd8597;

    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'd32;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'd10;

    typedef struct packed {
        logic [1:0]          operation;
        logic [LETTER_W-1:0] letter;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_GROUP_SPACE,
        JOB_GROUP_NEWLINE,
        JOB_RAW_NEWLINE
    } job_kind_t;

    typedef struct packed {
        job_kind_t                 kind;
        logic [2:0][LETTER_W-1:0]  letters;
        logic [1:0]                count;
    } job_t;

endpackage

// ===== hw/rtl/hill_cipher_3x3_decrypt_stream.sv =====
// top level: hill cipher 3x3 mod 26 decrypt stream
// an item is taken every cycle while the job queue has room; a group job
// then yields one character per cycle from the back sequencer while the output queue has room
// first character of a job reaches the result ports by way of the job queue write,
// the job load with products and the output queue write
// reset clears the group count, both queues and the sequencer, and loads
// the key rows with their default inverse key
module hill_cipher_3x3_decrypt_stream #(
    parameter int JOB_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  hcd_pkg::in_item_t             item,
    output logic                          empty,
    input  logic                          pop,
    output hcd_pkg::out_item_t            result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcd_pkg::KEY_W-1:0]     cfg_data
);

    import hcd_pkg::*;

    logic      job_push, job_full, job_pop, job_empty;
    job_t      job_in, job_out;
    logic      out_push, out_full;
    out_item_t out_item;

    assign full = job_full;

    hcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (job_full),
        .item     (item),
        .job_push (job_push),
        .job      (job_in)
    );

    hcd_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty)
    );

    hcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    hcd_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// ===== hw/rtl/hcd_fifo.sv =====
// small register queue used between the parts of the block
module hcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/hcd_front.sv =====
// front part: takes items, gathers letter groups, issues jobs
module hcd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  hcd_pkg::in_item_t item,
    output logic             job_push,
    output hcd_pkg::job_t    job
);

    import hcd_pkg::*;

    logic [2:0][LETTER_W-1:0] buf_reg, buf_next;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     accept;

    assign accept = push && !full;

    always_comb
    begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        job_push     = 1'b0;
        job.kind     = JOB_GROUP_SPACE;
        job.letters  = buf_reg;
        job.count    = cnt_reg;
        if (accept)
        begin
            case (item.operation)
                OP_LETTER:
                begin
                    if (cnt_reg == 2'd3)
                    begin
                        // full group goes out, new letter opens the next one
                        job_push    = 1'b1;
                        buf_next[0] = item.letter;
                        cnt_next    = 2'd1;
                    end
                    else
                    begin
                        buf_next[cnt_reg] = item.letter;
                        cnt_next          = cnt_reg + 2'd1;
                    end
                end
                OP_EOL:
                begin
                    job_push = 1'b1;
                    job.kind = (cnt_reg == 2'd3) ? JOB_GROUP_NEWLINE : JOB_RAW_NEWLINE;
                    cnt_next = 2'd0;
                end
                default:
                begin
                    // space and unused code: nothing to do
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== hw/rtl/hcd_back.sv =====
// back part: key registers, group product and character sequencer
module hcd_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcd_pkg::KEY_W-1:0]          cfg_data,
    input  logic                               job_empty,
    input  hcd_pkg::job_t                      job,
    output logic                               job_pop,
    input  logic                               out_full,
    output logic                               out_push,
    output hcd_pkg::out_item_t                 out_item
);

    import hcd_pkg::*;

    localparam logic [23:0] RECIP_26 = 24'd2520;

    logic [KEY_W-1:0]          key_reg [3];
    logic [KEY_W-1:0]          key_next [3];

    logic                      valid_reg, valid_next;
    job_kind_t                 kind_reg, kind_next;
    logic [2:0][LETTER_W-1:0]  letters_reg, letters_next;
    logic [1:0]                count_reg, count_next;
    logic [SUM_W-1:0]          sums_reg [3];
    logic [SUM_W-1:0]          sums_next [3];
    logic [1:0]                idx_reg, idx_next;

    logic                      emit, last_char, done, load;
    logic [SUM_W-1:0]          sum_sel;
    logic [LETTER_W-1:0]       letter_sel;

    function automatic logic [SUM_W-1:0] row_sum(input logic [KEY_W-1:0] row,
                                                  input logic [2:0][LETTER_W-1:0] l);
        logic [9:0] p0, p1, p2;
        p0 = 10'(row[4:0])   * 10'(l[0]);
        p1 = 10'(row[9:5])   * 10'(l[1]);
        p2 = 10'(row[14:10]) * 10'(l[2]);
        return SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
    endfunction

    // reciprocal estimate is low by at most one, one correction fixes it
    function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
        logic [23:0]      prod;
        logic [7:0]       q;
        logic [SUM_W-1:0] qm;
        logic [SUM_W-1:0] r;
        prod = 24'(x) * RECIP_26;
        q    = prod[23:16];
        qm   = SUM_W'({4'b0, q} << 4) + SUM_W'({4'b0, q} << 3) + SUM_W'({4'b0, q} << 1);
        r    = x - qm;
        if (r >= SUM_W'(26))
        begin
            r = r - SUM_W'(26);
        end
        return r[LETTER_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_next[0] = key_reg[0];
        key_next[1] = key_reg[1];
        key_next[2] = key_reg[2];
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_ROW0: key_next[0] = cfg_data;
                CFG_KEY_ROW1: key_next[1] = cfg_data;
                CFG_KEY_ROW2: key_next[2] = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign emit      = valid_reg && !out_full;
    assign last_char = (kind_reg == JOB_RAW_NEWLINE) ? (idx_reg == count_reg)
                                                     : (idx_reg == 2'd3);
    assign done      = emit && last_char;
    assign load      = !job_empty && (!valid_reg || done);
    assign job_pop   = load;
    assign out_push  = emit;

    assign sum_sel    = (idx_reg == 2'd2) ? sums_reg[2] :
                        (idx_reg == 2'd1) ? sums_reg[1] : sums_reg[0];
    assign letter_sel = (idx_reg == 2'd1) ? letters_reg[1] : letters_reg[0];

    always_comb
    begin
        out_item.last = last_char;
        if (kind_reg == JOB_RAW_NEWLINE)
        begin
            // partial group goes out as plain letters
            out_item.out_char = last_char ? CH_NEWLINE
                                          : CHAR_W'(letter_sel) + ASCII_A;
        end
        else if (idx_reg == 2'd3)
        begin
            out_item.out_char = (kind_reg == JOB_GROUP_SPACE) ? CH_SPACE : CH_NEWLINE;
        end
        else
        begin
            out_item.out_char = CHAR_W'(mod26(sum_sel)) + ASCII_A;
        end
    end

    always_comb
    begin
        valid_next   = valid_reg;
        kind_next    = kind_reg;
        letters_next = letters_reg;
        count_next   = count_reg;
        sums_next[0] = sums_reg[0];
        sums_next[1] = sums_reg[1];
        sums_next[2] = sums_reg[2];
        idx_next     = idx_reg;
        if (load)
        begin
            valid_next   = 1'b1;
            kind_next    = job.kind;
            letters_next = job.letters;
            count_next   = job.count;
            sums_next[0] = row_sum(key_reg[0], job.letters);
            sums_next[1] = row_sum(key_reg[1], job.letters);
            sums_next[2] = row_sum(key_reg[2], job.letters);
            idx_next     = 2'd0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= KEY_ROW0_RESET;
            key_reg[1] <= KEY_ROW1_RESET;
            key_reg[2] <= KEY_ROW2_RESET;
            valid_reg  <= 1'b0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            key_reg[0] <= key_next[0];
            key_reg[1] <= key_next[1];
            key_reg[2] <= key_next[2];
            valid_reg  <= valid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        letters_reg <= letters_next;
        count_reg   <= count_next;
        sums_reg[0] <= sums_next[0];
        sums_reg[1] <= sums_next[1];
        sums_reg[2] <= sums_next[2];
    end

    a_push_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> valid_reg)
        else $error("character pushed with no job in work");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load) |=> !valid_reg)
        else $error("job still held after its final character");

    a_raw_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == JOB_RAW_NEWLINE) |-> (idx_reg <= count_reg))
        else $error("raw job index ran past its letter count");

    a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last_char) |=> (idx_reg == $past(idx_reg) + 2'd1))
        else $error("character index did not advance");

endmodule

// ===== bench/hcd_stream_checker.sv =====
// checker for the hill cipher decrypt stream: predicts output characters and compares them
module hcd_stream_checker
    import hcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  in_item_t             item,
    input  logic                 empty,
    input  logic                 pop,
    input  out_item_t            result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [KEY_W-1:0]    key_rows [3];
    logic [LETTER_W-1:0] group_letters [3];
    logic [1:0]          group_len;
    out_item_t           expected_chars [$];

    // one plaintext capital: key row times the held group, mod 26
    function automatic logic [CHAR_W-1:0] plain_char(input int row);
        logic [SUM_W-1:0] sum;
        sum = '0;
        for (int j = 0; j < 3; j++)
            sum += SUM_W'(key_rows[row][LETTER_W*j +: LETTER_W]) * SUM_W'(group_letters[j]);
        return CHAR_W'((sum % SUM_W'(26)) + SUM_W'(ASCII_A));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [CHAR_W-1:0] chars [$];
        out_item_t         want;
        if (!rst_n)
        begin
            key_rows[0] = KEY_ROW0_RESET;
            key_rows[1] = KEY_ROW1_RESET;
            key_rows[2] = KEY_ROW2_RESET;
            group_letters = '{default: '0};
            group_len = '0;
            expected_chars.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual char %0d last %0b",
                             $time, result.out_char, result.last);
                    errors++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (result.out_char !== want.out_char)
                    begin
                        $display("%0t: out_char mismatch, expected %0d actual %0d",
                                 $time, want.out_char, result.out_char);
                        errors++;
                    end
                    if (result.last !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %0b actual %0b",
                                 $time, want.last, result.last);
                        errors++;
                    end
                end
            end

            if (push && !full)
            begin
                chars.delete();
                case (item.operation)
                    OP_LETTER:
                    begin
                        if (group_len == 2'd3)
                        begin
                            for (int r = 0; r < 3; r++)
                                chars = {chars, plain_char(r)};
                            chars = {chars, CH_SPACE};
                            group_letters = '{item.letter, '0, '0};
                            group_len = 2'd1;
                        end
                        else
                        begin
                            group_letters[group_len] = item.letter;
                            group_len++;
                        end
                    end
                    OP_EOL:
                    begin
                        if (group_len == 2'd3)
                            for (int r = 0; r < 3; r++)
                                chars = {chars, plain_char(r)};
                        else
                            // partial group goes out as plain letters
                            for (int i = 0; i < group_len; i++)
                                chars = {chars, CHAR_W'(group_letters[i]) + ASCII_A};
                        chars = {chars, CH_NEWLINE};
                        group_letters = '{default: '0};
                        group_len = '0;
                    end
                    default: ; // space and the unused code are skipped
                endcase
                for (int i = 0; i < chars.size(); i++)
                begin
                    want.out_char = chars[i];
                    want.last = (i == chars.size() - 1);
                    expected_chars = {expected_chars, want};
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_KEY_ROW0: key_rows[0] = cfg_data;
                    CFG_KEY_ROW1: key_rows[1] = cfg_data;
                    CFG_KEY_ROW2: key_rows[2] = cfg_data;
                    default: ;
                endcase
            end

            pending = expected_chars.size();
        end
    end

endmodule

// ===== bench/tb_hill_cipher_3x3_decrypt_stream.sv =====
// testbench top for the hill cipher decrypt stream: stimulus, key settings and verdict
module tb_hill_cipher_3x3_decrypt_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import hcd_pkg::*;

    localparam logic [1:0]           OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE    = 2'd3;
    localparam logic [KEY_W-1:0]     KEY_ALL_ONES = 15'h7FFF;
    localparam logic [KEY_W-1:0]     KEY_MAX_VALID = 15'd26425;
    localparam int                   PHASES      = 6;
    localparam int                   PHASE_ITEMS = 70;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    in_item_t             item = '0;
    logic                 pop = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data = '0;
    logic                 full;
    logic                 empty;
    logic                 cfg_ready;
    out_item_t            result;
    int                   errors;
    int                   pending;
    int                   burst_left = 0;

    always #5 clk = ~clk;

    hill_cipher_3x3_decrypt_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hcd_stream_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // push one item, then keep the burst going or take a gap
    task automatic send_item(input logic [1:0] op, input logic [LETTER_W-1:0] ltr);
        push <= 1'b1;
        item <= '{operation: op, letter: ltr};
        do @(posedge clk); while (full);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // hold off the sender until every predicted character has come out
    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_keys(input logic [KEY_W-1:0] r0, input logic [KEY_W-1:0] r1,
                              input logic [KEY_W-1:0] r2);
        logic [KEY_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] idxs [4];
        vals = '{r0, r1, r2, KEY_W'($urandom)};
        idxs = '{CFG_KEY_ROW0, CFG_KEY_ROW1, CFG_KEY_ROW2, CFG_NONE};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] valid_row();
        return {5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
                5'($urandom_range(0, 25))};
    endfunction

    task automatic send_random_item();
        int                  r;
        logic [1:0]          op;
        logic [LETTER_W-1:0] ltr;
        r = $urandom_range(0, 99);
        ltr = LETTER_W'($urandom);
        if (r < 68)
        begin
            op = OP_LETTER;
            ltr = ($urandom_range(0, 19) == 0) ? LETTER_W'($urandom_range(26, 31))
                                               : LETTER_W'($urandom_range(0, 25));
        end
        else if (r < 80)
            op = OP_SPACE;
        else if (r < 94)
            op = OP_EOL;
        else
            op = OP_UNUSED;
        send_item(op, ltr);
    endtask

    // receiver: steady, coin-flip and mostly-stalled stretches
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            for (int c = 0; c < span; c++)
            begin
                @(posedge clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default key: empty line, full group with out-of-range letter, partial groups
        send_item(OP_EOL, 5'd0);
        send_item(OP_LETTER, 5'd0);
        send_item(OP_LETTER, 5'd25);
        send_item(OP_LETTER, 5'd31);
        send_item(OP_EOL, 5'd0);
        send_item(OP_LETTER, 5'd31);
        send_item(OP_EOL, 5'd31);
        send_item(OP_LETTER, 5'd30);
        send_item(OP_SPACE, 5'd31);
        send_item(OP_LETTER, 5'd0);
        send_item(OP_EOL, 5'd0);
        // fourth letter closes a group, unused code is skipped
        send_item(OP_LETTER, 5'd1);
        send_item(OP_LETTER, 5'd2);
        send_item(OP_LETTER, 5'd3);
        send_item(OP_LETTER, 5'd4);
        send_item(OP_UNUSED, 5'd31);
        send_item(OP_LETTER, 5'd5);
        send_item(OP_LETTER, 5'd6);
        send_item(OP_SPACE, 5'd0);
        send_item(OP_LETTER, 5'd7);
        send_item(OP_EOL, 5'd0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       write_keys('0, '0, '0);
                1:       write_keys(KEY_ALL_ONES, KEY_ALL_ONES, KEY_ALL_ONES);
                2:       write_keys(KEY_MAX_VALID, KEY_MAX_VALID, KEY_MAX_VALID);
                5:       write_keys(KEY_W'($urandom), valid_row(), KEY_W'($urandom));
                default: write_keys(valid_row(), valid_row(), valid_row());
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    wait_drained();
                send_random_item();
            end
            wait_drained();
        end

        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_fifo.sv
hw/rtl/hcd_front.sv
hw/rtl/hcd_back.sv
hw/rtl/hill_cipher_3x3_decrypt_stream.sv
bench/hcd_stream_checker.sv
bench/tb_hill_cipher_3x3_decrypt_stream.sv
